@@ rtl/sle_pkg.sv @@
// ============================================================================
// sle_pkg - sprite line engine shared definitions
// Constants, command and register codes, and the compare unit result type.
// ============================================================================
package sle_pkg;

    localparam int MEM_DEPTH = 16384;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COLOR_W    = 4;
    localparam int OVF_IDX_W  = 5;

    // item commands
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_BASE  = 2'd3;

    localparam logic [7:0] Y_END          = 8'hD0;  // end of attribute table
    localparam logic [7:0] EARLY_SHIFT    = 8'd32;
    localparam logic [7:0] PAT_LARGE_MASK = 8'hFC;

    typedef struct packed {
        logic       hit;   // a within [b, b + limit], no wrap on the top
        logic [7:0] diff;  // a - b, 8-bit wrap
    } t_span;

endpackage

@@ rtl/sle_in_if.sv @@
// ============================================================================
// sle_in_if - item channel
// Valid/ready channel carrying one command beat.
// ============================================================================
interface sle_in_if;
    import sle_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [MEM_AW-1:0] mem_address;
    logic [7:0]        mem_data;
    logic [7:0]        line_offset;
    logic [7:0]        pixel_offset;

    modport source (
        output valid, cmd, mem_address, mem_data, line_offset, pixel_offset,
        input  ready
    );
    modport sink (
        input  valid, cmd, mem_address, mem_data, line_offset, pixel_offset,
        output ready
    );
endinterface

@@ rtl/sle_out_if.sv @@
// ============================================================================
// sle_out_if - result channel
// Valid/ready channel carrying sprite color and status flags.
// ============================================================================
interface sle_out_if;
    import sle_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COLOR_W-1:0]   sprite_color;
    logic                 collision;
    logic                 overflow;
    logic [OVF_IDX_W-1:0] overflow_index;

    modport source (
        output valid, sprite_color, collision, overflow, overflow_index,
        input  ready
    );
    modport sink (
        input  valid, sprite_color, collision, overflow, overflow_index,
        output ready
    );
endinterface

@@ rtl/sle_ram.sv @@
// ============================================================================
// sle_ram - single-port RAM
// One access per cycle, write or read, read data registered.
// ============================================================================
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sle_span.sv @@
// ============================================================================
// sle_span - shared span compare unit
// Difference a - b and test of a against the range [b, b + limit].
// ============================================================================
module sle_span (
    input  logic [7:0]    i_a,
    input  logic [7:0]    i_b,
    input  logic [4:0]    i_limit,
    output sle_pkg::t_span o_res
);
    import sle_pkg::*;

    logic [8:0] top;

    // upper bound kept 9 bits wide so it does not wrap
    assign top         = {1'b0, i_b} + {4'b0, i_limit};
    assign o_res.diff  = i_a - i_b;
    assign o_res.hit   = (i_a >= i_b) && ({1'b0, i_a} <= top);
endmodule

@@ rtl/sprite_line_eval_and_pixel_core.sv @@
// ============================================================================
// sprite_line_eval_and_pixel_core - sprite line evaluation and pixel unit
// Holds video memory, walks the attribute table per line into up to
// LINE_SLOTS slots, and renders sprite pixels with collision and overflow.
//
//   channel   dir   beat contents
//   i_item    in    cmd, mem_address, mem_data, line_offset, pixel_offset
//   o_result  out   sprite_color, collision, overflow, overflow_index
//   i_cfg_*   in    write enable, register index, data (no handshake)
//
// Write beat: one memory write. Line beat: a pass through the Y, X, pattern and
// extra states per attribute entry walked (up to 32 entries), with the reads
// serialized on the single video memory port. Pixel beat: an X compare per slot,
// plus a pattern read and a bit test per hit sprite (up to 4 slots).
// After reset a clearing pass zeroes all 16384 bytes of video memory with
// i_item.ready low; configuration writes are taken throughout.
// A result waiting in the output register holds the sequencer in its result
// state, so i_item.ready stays low until the register drains.
// ============================================================================
module sprite_line_eval_and_pixel_core #(
    parameter int LINE_SLOTS   = 4,
    parameter int ATTR_ENTRIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sle_in_if.sink                        i_item,
    sle_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sle_pkg::*;

    localparam int CNT_W   = $clog2(LINE_SLOTS + 1);
    localparam int SLOT_IW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int ENT_W   = (ATTR_ENTRIES > 1) ? $clog2(ATTR_ENTRIES) : 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE,
        ST_EV_INIT, ST_EV_Y, ST_EV_X, ST_EV_PAT, ST_EV_EXTRA,
        ST_RD_X, ST_RD_Y, ST_RD_BIT, ST_RESULT
    } t_state;

    // configuration
    logic                 r_large, r_zoom;
    logic [6:0]           r_attr_base;
    logic [2:0]           r_pat_base;

    // sequencer
    t_state               r_state, n_state;
    logic [MEM_AW-1:0]    r_clr_addr, n_clr_addr;
    logic [MEM_AW-1:0]    r_mem_addr, n_mem_addr;
    logic [7:0]           r_mem_data, n_mem_data;
    logic [7:0]           r_line, n_line;
    logic [7:0]           r_col, n_col;
    logic [MEM_AW-1:0]    r_addr, n_addr;
    logic [ENT_W-1:0]     r_entry, n_entry;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_slot, n_slot;
    logic [7:0]           r_ey, n_ey;
    logic [7:0]           r_ex, n_ex;
    logic [7:0]           r_ep, n_ep;
    logic [4:0]           r_px, n_px;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic                 r_coll, n_coll;
    logic                 r_ovf, n_ovf;
    logic [OVF_IDX_W-1:0] r_ovf_idx, n_ovf_idx;

    logic [7:0]           r_slot_y   [LINE_SLOTS];
    logic [7:0]           r_slot_x   [LINE_SLOTS];
    logic [7:0]           r_slot_pat [LINE_SLOTS];
    logic [COLOR_W-1:0]   r_slot_col [LINE_SLOTS];
    logic [7:0]           n_slot_y   [LINE_SLOTS];
    logic [7:0]           n_slot_x   [LINE_SLOTS];
    logic [7:0]           n_slot_pat [LINE_SLOTS];
    logic [COLOR_W-1:0]   n_slot_col [LINE_SLOTS];

    logic                 r_out_valid, n_out_valid;
    logic [COLOR_W-1:0]   r_out_color, n_out_color;
    logic                 r_out_coll, n_out_coll;
    logic                 r_out_ovf, n_out_ovf;
    logic [OVF_IDX_W-1:0] r_out_ovf_idx, n_out_ovf_idx;

    // memory port and compare unit
    logic                 ram_we;
    logic [MEM_AW-1:0]    ram_addr;
    logic [7:0]           ram_wdata;
    logic [7:0]           ram_rdata;
    logic [7:0]           span_a, span_b;
    logic [4:0]           span_limit;
    t_span                span;

    logic [SLOT_IW-1:0]   slot_idx;
    logic [SLOT_IW-1:0]   fill_idx;
    logic [7:0]           row;
    logic [10:0]          pat_off;

    assign slot_idx   = r_slot[SLOT_IW-1:0];
    assign fill_idx   = r_count[SLOT_IW-1:0];
    // 7, 15 or 31
    assign span_limit = {r_large & r_zoom, r_large | r_zoom, 3'b111};
    assign row        = span.diff >> r_zoom;
    assign pat_off    = {r_slot_pat[slot_idx], 3'b000}
                      + {5'b0, r_px[4:3], 4'b0000}
                      + {3'b000, row};

    sle_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sle_span u_span (
        .i_a     (span_a),
        .i_b     (span_b),
        .i_limit (span_limit),
        .o_res   (span)
    );

    assign i_item.ready            = (r_state == ST_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.sprite_color   = r_out_color;
    assign o_result.collision      = r_out_coll;
    assign o_result.overflow       = r_out_ovf;
    assign o_result.overflow_index = r_out_ovf_idx;

    // compare unit operand select
    always_comb begin
        span_a = r_line;
        span_b = r_ey;
        case (r_state)
            ST_RD_X: begin
                span_a = r_col;
                span_b = r_slot_x[slot_idx];
            end
            ST_RD_Y: begin
                span_a = r_line;
                span_b = r_slot_y[slot_idx];
            end
            default: begin
                span_a = r_line;
                span_b = r_ey;
            end
        endcase
    end

    always_comb begin
        logic [7:0] x_adj;
        logic       full;

        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_mem_addr    = r_mem_addr;
        n_mem_data    = r_mem_data;
        n_line        = r_line;
        n_col         = r_col;
        n_addr        = r_addr;
        n_entry       = r_entry;
        n_count       = r_count;
        n_slot        = r_slot;
        n_ey          = r_ey;
        n_ex          = r_ex;
        n_ep          = r_ep;
        n_px          = r_px;
        n_color       = r_color;
        n_coll        = r_coll;
        n_ovf         = r_ovf;
        n_ovf_idx     = r_ovf_idx;
        n_slot_y      = r_slot_y;
        n_slot_x      = r_slot_x;
        n_slot_pat    = r_slot_pat;
        n_slot_col    = r_slot_col;
        n_out_valid   = r_out_valid;
        n_out_color   = r_out_color;
        n_out_coll    = r_out_coll;
        n_out_ovf     = r_out_ovf;
        n_out_ovf_idx = r_out_ovf_idx;
        ram_we        = 1'b0;
        ram_addr      = r_addr;
        ram_wdata     = r_mem_data;
        x_adj         = ram_rdata[7] ? (r_ex - EARLY_SHIFT) : r_ex;
        full          = (r_count == CNT_W'(LINE_SLOTS));

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata  = 8'h00;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {MEM_AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_mem_addr = i_item.mem_address;
                    n_mem_data = i_item.mem_data;
                    n_line     = i_item.line_offset;
                    n_col      = i_item.pixel_offset;
                    n_slot     = '0;
                    n_color    = '0;
                    case (i_item.cmd)
                        CMD_WRITE:  n_state = ST_WRITE;
                        CMD_EVAL:   n_state = ST_EV_INIT;
                        CMD_RENDER: n_state = ST_RD_X;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                ram_we   = 1'b1;
                ram_addr = r_mem_addr;
                n_state  = ST_IDLE;
            end
            ST_EV_INIT: begin
                ram_addr  = {r_attr_base, 7'b0};
                n_addr    = {r_attr_base, 7'b0};
                n_entry   = '0;
                n_count   = '0;
                n_coll    = 1'b0;
                n_ovf     = 1'b0;
                n_ovf_idx = '0;
                n_state   = ST_EV_Y;
            end
            ST_EV_Y: begin
                ram_addr = r_addr + MEM_AW'(1);
                if (ram_rdata == Y_END) begin
                    n_state = ST_RESULT;
                end else begin
                    n_ey    = ram_rdata + 8'd1;
                    n_state = ST_EV_X;
                end
            end
            ST_EV_X: begin
                ram_addr = r_addr + MEM_AW'(2);
                n_ex     = ram_rdata;
                n_state  = ST_EV_PAT;
            end
            ST_EV_PAT: begin
                ram_addr = r_addr + MEM_AW'(3);
                n_ep     = r_large ? (ram_rdata & PAT_LARGE_MASK) : ram_rdata;
                n_state  = ST_EV_EXTRA;
            end
            ST_EV_EXTRA: begin
                // next entry's Y read goes out now
                ram_addr = r_addr + MEM_AW'(4);
                if (span.hit && full) begin
                    n_ovf     = 1'b1;
                    n_ovf_idx = OVF_IDX_W'(r_entry);
                    n_state   = ST_RESULT;
                end else begin
                    if (span.hit) begin
                        n_slot_y[fill_idx]   = r_ey;
                        n_slot_x[fill_idx]   = x_adj;
                        n_slot_pat[fill_idx] = r_ep;
                        n_slot_col[fill_idx] = ram_rdata[COLOR_W-1:0];
                        n_count              = r_count + 1'b1;
                    end
                    if (r_entry == ENT_W'(ATTR_ENTRIES - 1)) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_entry = r_entry + 1'b1;
                        n_addr  = r_addr + MEM_AW'(4);
                        n_state = ST_EV_Y;
                    end
                end
            end
            ST_RD_X: begin
                if (r_slot == r_count) begin
                    n_state = ST_RESULT;
                end else if (!span.hit) begin
                    n_slot = r_slot + 1'b1;
                end else begin
                    n_px    = 5'(span.diff >> r_zoom);
                    n_state = ST_RD_Y;
                end
            end
            ST_RD_Y: begin
                ram_addr = {r_pat_base, pat_off};
                n_state  = ST_RD_BIT;
            end
            ST_RD_BIT: begin
                n_slot  = r_slot + 1'b1;
                n_state = ST_RD_X;
                if (ram_rdata[~r_px[2:0]]) begin
                    if (r_color != '0) begin
                        n_coll  = 1'b1;
                        n_state = ST_RESULT;
                    end else begin
                        n_color = r_slot_col[slot_idx];
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_color   = r_color;
                    n_out_coll    = n_coll;
                    n_out_ovf     = n_ovf;
                    n_out_ovf_idx = n_ovf_idx;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_entry     <= '0;
            r_count     <= '0;
            r_slot      <= '0;
            r_coll      <= 1'b0;
            r_ovf       <= 1'b0;
            r_ovf_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_entry     <= n_entry;
            r_count     <= n_count;
            r_slot      <= n_slot;
            r_coll      <= n_coll;
            r_ovf       <= n_ovf;
            r_ovf_idx   <= n_ovf_idx;
            r_out_valid <= n_out_valid;
        end
        r_mem_addr    <= n_mem_addr;
        r_mem_data    <= n_mem_data;
        r_line        <= n_line;
        r_col         <= n_col;
        r_addr        <= n_addr;
        r_ey          <= n_ey;
        r_ex          <= n_ex;
        r_ep          <= n_ep;
        r_px          <= n_px;
        r_color       <= n_color;
        r_slot_y      <= n_slot_y;
        r_slot_x      <= n_slot_x;
        r_slot_pat    <= n_slot_pat;
        r_slot_col    <= n_slot_col;
        r_out_color   <= n_out_color;
        r_out_coll    <= n_out_coll;
        r_out_ovf     <= n_out_ovf;
        r_out_ovf_idx <= n_out_ovf_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_large     <= 1'b0;
            r_zoom      <= 1'b0;
            r_attr_base <= '0;
            r_pat_base  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LARGE:     r_large     <= i_cfg_data[0];
                CFG_ZOOM:      r_zoom      <= i_cfg_data[0];
                CFG_ATTR_BASE: r_attr_base <= i_cfg_data[6:0];
                CFG_PAT_BASE:  r_pat_base  <= i_cfg_data[2:0];
                default:       r_large     <= r_large;
            endcase
        end
    end

`ifndef SYNTH
    // an accepted write beat reaches the memory on the next cycle
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.cmd == CMD_WRITE) |=> ram_we)
        else $error("accepted write beat did not reach video memory");

    // a finished result waits while the output register is still occupied
    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_out_valid && !o_result.ready)
        |=> (r_state == ST_RESULT))
        else $error("result dropped over a pending output beat");

    // overflow is only raised once every slot is taken
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(LINE_SLOTS)))
        else $error("overflow set with free sprite slots");
`endif

endmodule
